FILE: rtl/ntd_pkg.sv
// ----------------------------------------------------------------------------
// ntd_pkg
// Shared types, codes and code page tables of the nibble table text
// decompressor.
// ----------------------------------------------------------------------------
package ntd_pkg;

  localparam int unsigned TblEntries = 14;
  localparam int unsigned TblBits    = TblEntries * 8;

  // nibble codes
  localparam logic [3:0] NibRaw = 4'hF;
  localparam logic [3:0] NibRep = 4'hE;

  // characters that are dropped
  localparam logic [7:0] ChDropA = 8'h01;
  localparam logic [7:0] ChDropB = 8'h02;

  // decode phase codes
  localparam logic [1:0] PhPlain = 2'd0;
  localparam logic [1:0] PhCount = 2'd1;
  localparam logic [1:0] PhRawLo = 2'd2;
  localparam logic [1:0] PhRawHi = 2'd3;

  // configuration register indexes
  localparam logic CfgTblLow  = 1'b0;
  localparam logic CfgTblHigh = 1'b1;

  typedef struct packed {
    logic       emit;   // a character is to be sent
    logic [7:0] value;  // the character
    logic [4:0] reps;   // how many times it is sent
    logic [1:0] phase;
    logic [3:0] raw;
    logic [4:0] count;
  } dec_res_t;

  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] bytes;  // byte 0 goes out first
  } utf8_t;

  localparam logic [15:0] LowMap [32] = '{
    16'h000A, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
  };

  localparam logic [15:0] HighMap [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // table entry for a plain nibble; a nib of 14 or above gives 8'h00
  function automatic logic [7:0] tbl_entry(logic [TblBits-1:0] tbl, logic [3:0] nib);
    logic [7:0] res;
    res = 8'h00;
    for (int i = 0; i < TblEntries; i++) begin
      if (nib == i[3:0]) begin
        res = tbl[i*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/ntd_nibble_dec.sv
// ----------------------------------------------------------------------------
// ntd_nibble_dec
// Decodes one nibble against the current escape / repeat state. Shared by
// both nibbles of a byte, one per cycle while no output beat is pending.
// ----------------------------------------------------------------------------
module ntd_nibble_dec import ntd_pkg::*; (
  input  logic [TblBits-1:0] tbl_i,
  input  logic [3:0]         nib_i,
  input  logic [1:0]         phase_i,
  input  logic [3:0]         raw_i,
  input  logic [4:0]         count_i,
  output dec_res_t           res_o
);

  logic       have_char;
  logic [7:0] ch;

  always_comb begin
    have_char    = 1'b0;
    ch           = 8'h00;
    res_o.phase  = phase_i;
    res_o.raw    = raw_i;
    res_o.count  = count_i;
    case (phase_i)
      PhCount: begin
        res_o.count = {1'b0, nib_i} + 5'd1;
        res_o.phase = PhPlain;
      end
      PhRawLo: begin
        res_o.raw   = nib_i;
        res_o.phase = PhRawHi;
      end
      PhRawHi: begin
        res_o.phase = PhPlain;
        have_char   = 1'b1;
        ch          = {nib_i, raw_i};
      end
      default: begin
        if (nib_i == NibRaw) begin
          res_o.phase = PhRawLo;
        end else if (nib_i == NibRep) begin
          res_o.phase = PhCount;
        end else begin
          have_char = 1'b1;
          ch        = tbl_entry(tbl_i, nib_i);
        end
      end
    endcase

    res_o.value = ch;
    res_o.reps  = count_i + 5'd1;
    res_o.emit  = have_char && (ch != ChDropA) && (ch != ChDropB);
    // any character, sent or dropped, uses up the pending count
    if (have_char) begin
      res_o.count = 5'd0;
    end
  end

endmodule

FILE: rtl/ntd_utf8_enc.sv
// ----------------------------------------------------------------------------
// ntd_utf8_enc
// Maps a code page 437 character to its code point and encodes it as
// one to three UTF-8 bytes.
// ----------------------------------------------------------------------------
module ntd_utf8_enc import ntd_pkg::*; (
  input  logic [7:0] char_i,
  output utf8_t      enc_o
);

  logic [15:0] cp;

  always_comb begin
    if (char_i < 8'h20) begin
      cp = LowMap[char_i[4:0]];
    end else if (char_i < 8'h7F) begin
      cp = {8'h00, char_i};
    end else if (char_i == 8'h7F) begin
      cp = 16'h2302;
    end else begin
      cp = HighMap[char_i[6:0]];
    end

    if (cp < 16'h0080) begin
      enc_o.len      = 2'd1;
      enc_o.bytes[0] = cp[7:0];
      enc_o.bytes[1] = 8'h00;
      enc_o.bytes[2] = 8'h00;
    end else if (cp < 16'h0800) begin
      enc_o.len      = 2'd2;
      enc_o.bytes[0] = {3'b110, cp[10:6]};
      enc_o.bytes[1] = {2'b10, cp[5:0]};
      enc_o.bytes[2] = 8'h00;
    end else begin
      enc_o.len      = 2'd3;
      enc_o.bytes[0] = {4'b1110, cp[15:12]};
      enc_o.bytes[1] = {2'b10, cp[11:6]};
      enc_o.bytes[2] = {2'b10, cp[5:0]};
    end
  end

endmodule

FILE: rtl/nibble_table_text_decompressor.sv
// ----------------------------------------------------------------------------
// nibble_table_text_decompressor
// Expands nibble coded help text into UTF-8 bytes.
// ----------------------------------------------------------------------------
// One compressed byte at a time: the beat is taken, then each of its two
// nibbles passes in turn through the shared nibble decoder, and every UTF-8
// byte it produces takes one output beat, up to 54 per input byte. The sink
// may hold m_axis_tready low before any output beat. The input is not ready
// while a byte is being worked on. m_axis_tlast marks the last output byte
// caused by an input byte. The substitution table is written through the
// cfg port (index 0: entries 0..7, index 1: entries 8..13) while idle; the
// user is bound to that, as the block itself does not enforce it.
module nibble_table_text_decompressor import ntd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // end_of_record
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StNib  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [TblBits-1:0] tbl_q;
  logic [7:0]         byte_q, byte_d;
  logic               eor_q, eor_d;
  logic               sel_q, sel_d;
  logic [1:0]         phase_q, phase_d;
  logic [3:0]         raw_q, raw_d;
  logic [4:0]         count_q, count_d;
  utf8_t              chr_q, chr_d;
  logic [4:0]         rep_q, rep_d;
  logic [1:0]         idx_q, idx_d;
  logic               more_q, more_d;

  dec_res_t   dec;
  utf8_t      enc;
  logic [3:0] nib;
  logic [3:0] nib_hi;
  logic [7:0] hi_entry;
  logic       hi_emits;
  logic       char_end;
  logic       run_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTblLow:  tbl_q[63:0]        <= cfg_data_i;
        CfgTblHigh: tbl_q[TblBits-1:64] <= cfg_data_i[TblBits-65:0];
        default:    tbl_q              <= tbl_q;
      endcase
    end
  end

  assign nib = sel_q ? byte_q[7:4] : byte_q[3:0];

  ntd_nibble_dec u_dec (
    .tbl_i   (tbl_q),
    .nib_i   (nib),
    .phase_i (phase_q),
    .raw_i   (raw_q),
    .count_i (count_q),
    .res_o   (dec)
  );

  ntd_utf8_enc u_enc (
    .char_i (dec.value),
    .enc_o  (enc)
  );

  // after a character from the low nibble the decoder is plain with no count,
  // so whether the high nibble sends anything follows from the table alone
  assign nib_hi   = byte_q[7:4];
  assign hi_entry = tbl_entry(tbl_q, nib_hi);
  assign hi_emits = (nib_hi != NibRaw) && (nib_hi != NibRep) &&
                    (hi_entry != ChDropA) && (hi_entry != ChDropB);

  assign char_end = (idx_q == chr_q.len - 2'd1) && (rep_q == 5'd1);

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StEmit);
  assign m_axis_tdata  = chr_q.bytes[idx_q];
  assign m_axis_tlast  = char_end && (sel_q || !more_q);

  always_comb begin
    state_d = state_q;
    byte_d  = byte_q;
    eor_d   = eor_q;
    sel_d   = sel_q;
    phase_d = phase_q;
    raw_d   = raw_q;
    count_d = count_q;
    chr_d   = chr_q;
    rep_d   = rep_q;
    idx_d   = idx_q;
    more_d  = more_q;
    run_end = 1'b0;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          byte_d  = s_axis_tdata;
          eor_d   = s_axis_tlast;
          sel_d   = 1'b0;
          state_d = StNib;
        end
      end
      StNib: begin
        phase_d = dec.phase;
        raw_d   = dec.raw;
        count_d = dec.count;
        if (dec.emit) begin
          chr_d   = enc;
          rep_d   = dec.reps;
          idx_d   = 2'd0;
          more_d  = hi_emits;
          state_d = StEmit;
        end else if (!sel_q) begin
          sel_d = 1'b1;
        end else begin
          run_end = 1'b1;
        end
      end
      StEmit: begin
        if (m_axis_tready) begin
          if (idx_q != chr_q.len - 2'd1) begin
            idx_d = idx_q + 2'd1;
          end else if (rep_q != 5'd1) begin
            idx_d = 2'd0;
            rep_d = rep_q - 5'd1;
          end else if (!sel_q) begin
            sel_d   = 1'b1;
            state_d = StNib;
          end else begin
            run_end = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (run_end) begin
      state_d = StIdle;
      if (eor_q) begin
        phase_d = PhPlain;
        raw_d   = 4'd0;
        count_d = 5'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q   <= 1'b0;
      phase_q <= PhPlain;
      raw_q   <= 4'd0;
      count_q <= 5'd0;
      rep_q   <= 5'd0;
      idx_q   <= 2'd0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      phase_q <= phase_d;
      raw_q   <= raw_d;
      count_q <= count_d;
      rep_q   <= rep_d;
      idx_q   <= idx_d;
      more_q  <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eor_q  <= eor_d;
    chr_q  <= chr_d;
  end

  // input and output never both open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output beat pending");

  // an accepted byte starts with its low nibble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> (state_q == StNib) && !sel_q)
    else $error("byte not started on low nibble");

  // a character being sent has a live repeat count and a byte in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (rep_q != 5'd0) && (rep_q <= 5'd17) && (idx_q < chr_q.len))
    else $error("emit counters out of range");

  // pending repeat count never exceeds sixteen between characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 5'd16)
    else $error("repeat count out of range");

endmodule

FILE: test/tb_nibble_table_text_decompressor.sv
// ----------------------------------------------------------------------------
// tb_nibble_table_text_decompressor
// Self-checking bench for the nibble table text decompressor. A table of
// directed bytes covers the escapes, repeat counts, dropped characters, the
// end-of-record cleanup and the table extremes. Random phases follow, each
// with a fresh substitution table, feeding nibble streams built from raw,
// repeat and plain tokens mixed with noise bytes. Every output beat
// is compared with the beats given in its row or with an in-bench decoder model.
// Both stream sides idle at random, and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_nibble_table_text_decompressor import ntd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned RstCycles   = 9;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandPhases  = 5;
  localparam int unsigned PhaseItems  = 78;
  localparam int unsigned MaxBeats    = 54;
  localparam int unsigned MaxPrint    = 40;

  // code page 437 to unicode, control range and upper half
  localparam logic [15:0] UcsCtrl [32] = '{
    16'h000A, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
  };

  localparam logic [15:0] UcsUpper [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        cfg_idx;
    logic [63:0] value;        // compressed byte in the low bits, or register data
    logic        eor;
    logic        typed;        // expected beats given in the row
    logic [2:0]  n_typed;
    logic [31:0] typed_bytes;  // first beat in the low byte
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // data_byte[7:0]
  logic        s_axis_tlast  = 1'b0;   // end_of_record
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // out_byte[7:0]
  logic        m_axis_tlast;           // last_of_run
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = 1'b0;
  logic [63:0] cfg_data_i    = 64'h0;

  // decoder model state
  logic [1:0]  dec_phase = PhPlain;
  logic [3:0]  raw_lo    = 4'h0;
  logic [4:0]  rep_cnt   = 5'd0;
  logic [63:0] tbl_lo    = 64'h0;
  logic [47:0] tbl_hi    = 48'h0;

  utf8_beat_t  char_beats [$];   // beats of the byte being decoded
  utf8_beat_t  utf8_expect [$];  // beats still owed by the block
  utf8_beat_t  head_beat;
  dir_row_t    dir_rows [$];
  logic [3:0]  nib_q [$];

  int unsigned cycle_cnt  = 0;
  int unsigned err_cnt    = 0;
  int unsigned burst_left = 0;
  logic        hold_req   = 1'b0;
  logic        hold_done  = 1'b0;

  nibble_table_text_decompressor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #(HalfPeriod) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic [15:0] cp437_ucs(logic [7:0] c);
    if (c < 8'h20) return UcsCtrl[c[4:0]];
    if (c <= 8'h7E) return {8'h00, c};
    if (c == 8'h7F) return 16'h2302;
    return UcsUpper[c[6:0]];
  endfunction

  task automatic emit_char(input logic [7:0] ch);
    logic [15:0] cp;
    logic [7:0]  u [3];
    int          len;
    utf8_beat_t  bt;
    rep_cnt = rep_cnt + 5'd1;
    if (ch == ChDropA || ch == ChDropB) begin
      rep_cnt = 5'd0;
      return;
    end
    cp = cp437_ucs(ch);
    if (cp < 16'h0080) begin
      u[0] = cp[7:0];
      len  = 1;
    end else if (cp < 16'h0800) begin
      u[0] = 8'hC0 | {3'b000, cp[10:6]};
      u[1] = 8'h80 | {2'b00, cp[5:0]};
      len  = 2;
    end else begin
      u[0] = 8'hE0 | {4'h0, cp[15:12]};
      u[1] = 8'h80 | {2'b00, cp[11:6]};
      u[2] = 8'h80 | {2'b00, cp[5:0]};
      len  = 3;
    end
    for (int r = 0; r < rep_cnt; r++) begin
      for (int k = 0; k < len; k++) begin
        if (char_beats.size() < MaxBeats) begin
          bt.data = u[k];
          bt.last = 1'b0;
          char_beats.push_back(bt);
        end
      end
    end
    rep_cnt = 5'd0;
  endtask

  task automatic decode_nibble(input logic [3:0] nib);
    case (dec_phase)
      PhCount: begin
        rep_cnt   = {1'b0, nib} + 5'd1;
        dec_phase = PhPlain;
      end
      PhRawLo: begin
        raw_lo    = nib;
        dec_phase = PhRawHi;
      end
      PhRawHi: begin
        dec_phase = PhPlain;
        emit_char({nib, raw_lo});
      end
      default: begin
        if (nib == NibRaw) dec_phase = PhRawLo;
        else if (nib == NibRep) dec_phase = PhCount;
        else if (nib < 4'd8) emit_char(tbl_lo[nib*8 +: 8]);
        else emit_char(tbl_hi[(nib-4'd8)*8 +: 8]);
      end
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eor);
    utf8_beat_t bt;
    char_beats.delete();
    decode_nibble(b[3:0]);
    decode_nibble(b[7:4]);
    if (eor) begin
      dec_phase = PhPlain;
      raw_lo    = 4'h0;
      rep_cnt   = 5'd0;
    end
    if (char_beats.size() > 0) begin
      bt      = char_beats.pop_back();
      bt.last = 1'b1;
      char_beats.push_back(bt);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < MaxPrint) begin
      $display("mismatch %s: got %02h, expected %02h, cycle %0d",
               what, got, want, cycle_cnt);
    end
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (utf8_expect.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 8'h00);
      end else begin
        head_beat = utf8_expect.pop_front();
        if (m_axis_tdata !== head_beat.data) begin
          report_mismatch("out_byte", m_axis_tdata, head_beat.data);
        end
        if (m_axis_tlast !== head_beat.last) begin
          report_mismatch("last_of_run", {7'b0, m_axis_tlast}, {7'b0, head_beat.last});
        end
      end
    end
  end

  // ---------------------------------------------------------------- sink

  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        // long hold-off so the block backs up into its input
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = (mode_left % 4 == 0);
        default: m_axis_tready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- source

  task automatic add_byte_row(input logic [7:0] b, input logic eor);
    dir_row_t row;
    row = '0;
    row.kind  = RowByte;
    row.value = {56'h0, b};
    row.eor   = eor;
    dir_rows.push_back(row);
  endtask

  task automatic add_typed_row(input logic [7:0] b, input logic eor,
                               input logic [2:0] n, input logic [31:0] bytes);
    dir_row_t row;
    row = '0;
    row.kind        = RowByte;
    row.value       = {56'h0, b};
    row.eor         = eor;
    row.typed       = 1'b1;
    row.n_typed     = n;
    row.typed_bytes = bytes;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg_row(input logic idx, input logic [63:0] val);
    dir_row_t row;
    row = '0;
    row.kind    = RowCfg;
    row.cfg_idx = idx;
    row.value   = val;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eor, input logic typed,
                           input logic [2:0] n, input logic [31:0] bytes);
    utf8_beat_t bt;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 8);
    end
    s_axis_tdata  = b;
    s_axis_tlast  = eor;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, eor);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        bt.data = bytes[8*k +: 8];
        bt.last = (k == n - 1);
        utf8_expect.push_back(bt);
      end
    end else begin
      foreach (char_beats[k]) utf8_expect.push_back(char_beats[k]);
    end
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (utf8_expect.size() != 0) @(negedge clk_i);
    // a byte with no output may still be in flight
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_table_reg(input logic idx, input logic [63:0] val);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgTblLow) tbl_lo = val;
    else tbl_hi = val[47:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [7:0] pick_entry();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) == 0) ? ChDropA : ChDropB;
      1: return 8'h00;
      2: return 8'($urandom_range(8'h20, 8'h7F));
      default: return 8'($urandom);
    endcase
  endfunction

  // appends one token of compressed text to the nibble stream
  task automatic add_token();
    case ($urandom_range(0, 19))
      9, 10, 11, 12: begin
        nib_q.push_back(NibRep);
        nib_q.push_back(4'($urandom_range(0, 15)));
      end
      13, 14, 15, 16, 17: begin
        nib_q.push_back(NibRaw);
        nib_q.push_back(4'($urandom_range(0, 15)));
        nib_q.push_back(4'($urandom_range(0, 15)));
      end
      18: begin
        nib_q.push_back(NibRaw);
        nib_q.push_back(($urandom_range(0, 1) == 0) ? ChDropA[3:0] : ChDropB[3:0]);
        nib_q.push_back(4'h0);
      end
      19: begin
        nib_q.push_back(NibRep);
        nib_q.push_back(4'hF);
        nib_q.push_back(4'($urandom_range(0, 13)));
      end
      default: nib_q.push_back(4'($urandom_range(0, 13)));
    endcase
  endtask

  initial begin
    dir_row_t    row;
    logic [63:0] lo_val;
    logic [63:0] hi_val;
    logic [7:0]  b;
    logic        eor;

    // reset table: every plain nibble decodes to a newline
    add_typed_row(8'h00, 1'b0, 3'd2, 32'h0000_0A0A);
    add_typed_row(8'h0E, 1'b0, 3'd0, 32'h0);
    add_typed_row(8'h00, 1'b0, 3'd3, 32'h000A_0A0A);
    add_typed_row(8'hFF, 1'b1, 3'd0, 32'h0);           // escape cut off by end of record
    add_typed_row(8'h5E, 1'b1, 3'd0, 32'h0);           // count with no character
    add_typed_row(8'h00, 1'b1, 3'd2, 32'h0000_0A0A);
    add_cfg_row(CfgTblHigh, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg_row(CfgTblLow, 64'h7E7F_4120_8002_0103);
    add_typed_row(8'h88, 1'b0, 3'd4, 32'hA0C2_A0C2);
    add_byte_row(8'hFE, 1'b0);                         // largest count
    add_byte_row(8'h00, 1'b0);                         // most beats from one byte
    add_byte_row(8'h3E, 1'b0);
    add_byte_row(8'h5E, 1'b0);                         // second count replaces the first
    add_byte_row(8'h55, 1'b0);
    add_byte_row(8'h4E, 1'b0);
    add_byte_row(8'h11, 1'b0);                         // dropped table characters
    add_byte_row(8'h1F, 1'b0);
    add_byte_row(8'hF0, 1'b0);                         // dropped raw character
    add_byte_row(8'h27, 1'b0);
    add_byte_row(8'h76, 1'b0);
    add_byte_row(8'h9F, 1'b0);
    add_byte_row(8'h3B, 1'b0);
    add_byte_row(8'h0F, 1'b1);
    add_typed_row(8'h44, 1'b1, 3'd2, 32'h0000_2020);
    add_cfg_row(CfgTblLow, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg_row(CfgTblHigh, 64'h0);
    add_typed_row(8'h8D, 1'b1, 3'd2, 32'h0000_0A0A);
    add_typed_row(8'h70, 1'b1, 3'd4, 32'hA0C2_A0C2);

    repeat (RstCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.kind == RowCfg) begin
        wait_drained();
        write_table_reg(row.cfg_idx, row.value);
      end else begin
        send_byte(row.value[7:0], row.eor, row.typed, row.n_typed, row.typed_bytes);
      end
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_drained();
      for (int e = 0; e < 8; e++) lo_val[8*e +: 8] = pick_entry();
      hi_val = {$urandom, $urandom};
      for (int e = 0; e < 6; e++) hi_val[8*e +: 8] = pick_entry();
      write_table_reg(CfgTblLow, lo_val);
      write_table_reg(CfgTblHigh, hi_val);
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        while (nib_q.size() < 2) add_token();
        if ($urandom_range(0, 6) == 0) begin
          b = 8'($urandom);
        end else begin
          b[3:0] = nib_q.pop_front();
          b[7:4] = nib_q.pop_front();
        end
        eor = ($urandom_range(0, 9) == 0);
        send_byte(b, eor, 1'b0, 3'd0, 32'h0);
      end
    end

    wait_drained();
    repeat (DrainCycles * 2) @(negedge clk_i);
    if (err_cnt == 0 && utf8_expect.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ntd_pkg.sv
rtl/ntd_nibble_dec.sv
rtl/ntd_utf8_enc.sv
rtl/nibble_table_text_decompressor.sv
test/tb_nibble_table_text_decompressor.sv
